// File: rtl/dcds_pkg.sv
// ----------------------------------------------------------------------------
// Date check and day span: shared package
// Widths, status codes, the transaction types passed between the front end,
// the queue and the back end, and the calendar tables as functions.
// ----------------------------------------------------------------------------
package dcds_pkg;

   // Field widths of the request and response transactions.
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int TOTAL_W  = 22;
   localparam int STATUS_W = 3;

   // Largest year accepted; a larger year is handled like a missing field.
   localparam int MAX_YEAR = 9999;

   // Division by 100 as a multiply by a reciprocal: exact for any 14-bit value.
   localparam int RECIP_100   = 5243;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = YEAR_W + RECIP_W;
   localparam int CENT_W      = PROD_W - RECIP_SHIFT;

   // Day numbers from 1 January of year 1, wide enough for any 14-bit year.
   localparam int DAYNUM_W = 23;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // Queue between the front end and the back end.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   // Which date a bad month or bad day refers to.
   localparam logic BAD_FIRST = 1'b0;
   localparam logic BAD_LAST  = 1'b1;

   // Month codes used by the calendar tables.
   localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_MISSING     = 3'd1,
      ST_BAD_MONTH   = 3'd2,
      ST_BAD_DAY     = 3'd3,
      ST_YEAR_ORDER  = 3'd4,
      ST_MONTH_ORDER = 3'd5,
      ST_DAY_ORDER   = 3'd6
   } status_type;

   // One date as the back end needs it: year minus one and its hundreds.
   typedef struct packed {
      logic [YEAR_W-1:0]  prev_year;
      logic [CENT_W-1:0]  cent;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic               leap;
   } date_work_type;

   // A classified transaction waiting in the queue.
   typedef struct packed {
      status_type    status;
      logic          bad_date;
      date_work_type first;
      date_work_type last;
   } job_type;

   // Queue occupancy as seen by the front end and the back end.
   typedef struct packed {
      logic              valid;
      logic [QCNT_W-1:0] count;
   } queue_state_type;

   // Length of a month, or zero for a month code that means nothing.
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd1:    len = DAY_W'(31);
         4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
         4'd3:    len = DAY_W'(31);
         4'd4:    len = DAY_W'(30);
         4'd5:    len = DAY_W'(31);
         4'd6:    len = DAY_W'(30);
         4'd7:    len = DAY_W'(31);
         4'd8:    len = DAY_W'(31);
         4'd9:    len = DAY_W'(30);
         4'd10:   len = DAY_W'(31);
         4'd11:   len = DAY_W'(30);
         4'd12:   len = DAY_W'(31);
         default: len = '0;
      endcase
      return len;
   endfunction

   // Days in the year before the first of a month, common year.
   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month);
      logic [8:0] n;
      case (month)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

   // Day number of a valid date, with 1 January of year 1 as day 1.
   function automatic logic [DAYNUM_W-1:0] day_number(input date_work_type w);
      logic [DAYNUM_W-1:0] n;
      logic                feb_done;
      feb_done = (w.month > MONTH_FEB) && w.leap;
      n = DAYNUM_W'(w.prev_year) * DAYNUM_W'(365);
      n = n + DAYNUM_W'(w.prev_year >> 2) - DAYNUM_W'(w.cent) + DAYNUM_W'(w.cent >> 2)
            + DAYNUM_W'(days_before(w.month)) + DAYNUM_W'(feb_done) + DAYNUM_W'(w.day);
      return n;
   endfunction

endpackage

// File: rtl/dcds_front.sv
// ----------------------------------------------------------------------------
// Date check and day span: front end
// Accepts a request, divides both years minus one by 100, then checks both
// dates and their order and pushes the classified transaction into the queue.
// ----------------------------------------------------------------------------
module dcds_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [dcds_pkg::YEAR_W-1:0]      req_first_year,
   input  logic [dcds_pkg::MONTH_W-1:0]     req_first_month,
   input  logic [dcds_pkg::DAY_W-1:0]       req_first_day,
   input  logic [dcds_pkg::YEAR_W-1:0]      req_last_year,
   input  logic [dcds_pkg::MONTH_W-1:0]     req_last_month,
   input  logic [dcds_pkg::DAY_W-1:0]       req_last_day,
   input  dcds_pkg::queue_state_type        q_state,
   output logic                             push,
   output dcds_pkg::job_type                push_job
);

   // Stage one registers.
   logic                             f1_valid_ff, f1_valid_in;
   logic [dcds_pkg::YEAR_W-1:0]      fy_ff, ly_ff;
   logic [dcds_pkg::MONTH_W-1:0]     fm_ff, lm_ff;
   logic [dcds_pkg::DAY_W-1:0]       fd_ff, ld_ff;
   logic [dcds_pkg::YEAR_W-1:0]      fp_ff, fp_in, lp_ff, lp_in;
   logic [dcds_pkg::CENT_W-1:0]      fc_ff, fc_in, lc_ff, lc_in;
   logic [dcds_pkg::PROD_W-1:0]      fprod, lprod;
   logic                             accept;
   logic [dcds_pkg::QCNT_W:0]        pending;

   // Stage two classification.
   logic                             leap_f, leap_l;
   logic                             missing;
   logic                             month_bad_f, month_bad_l, day_bad_f, day_bad_l;
   dcds_pkg::status_type             status;
   logic                             bad_date;

   // A year is a leap year when divisible by 4 but not by 100, or by 400.
   // Year divisible by 100 shows as year minus one leaving 99 over 100.
   function automatic logic leap_of(input logic [dcds_pkg::YEAR_W-1:0] year,
                                    input logic [dcds_pkg::YEAR_W-1:0] prev,
                                    input logic [dcds_pkg::CENT_W-1:0] cent);
      logic [dcds_pkg::YEAR_W-1:0] rem;
      logic                        century;
      rem = prev - dcds_pkg::YEAR_W'(cent) * dcds_pkg::YEAR_W'(100);
      century = (rem == dcds_pkg::YEAR_W'(99));
      return ((year[1:0] == 2'b00) && !century) || (century && (cent[1:0] == 2'b11));
   endfunction

   // Hold off new transactions while the queue could not take everything in flight.
   always_comb begin
      pending = {1'b0, q_state.count} + {{dcds_pkg::QCNT_W{1'b0}}, f1_valid_ff};
      busy    = reset || (pending >= (dcds_pkg::QCNT_W + 1)'(dcds_pkg::QDEPTH));
      accept  = start && !busy;
   end

   // Year minus one, divided by 100 through its reciprocal.
   always_comb begin
      fp_in       = req_first_year - dcds_pkg::YEAR_W'(1);
      lp_in       = req_last_year - dcds_pkg::YEAR_W'(1);
      fprod       = dcds_pkg::PROD_W'(fp_in) * dcds_pkg::PROD_W'(dcds_pkg::RECIP_100);
      lprod       = dcds_pkg::PROD_W'(lp_in) * dcds_pkg::PROD_W'(dcds_pkg::RECIP_100);
      fc_in       = fprod[dcds_pkg::PROD_W-1:dcds_pkg::RECIP_SHIFT];
      lc_in       = lprod[dcds_pkg::PROD_W-1:dcds_pkg::RECIP_SHIFT];
      f1_valid_in = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fy_ff <= req_first_year;
         fm_ff <= req_first_month;
         fd_ff <= req_first_day;
         ly_ff <= req_last_year;
         lm_ff <= req_last_month;
         ld_ff <= req_last_day;
         fp_ff <= fp_in;
         lp_ff <= lp_in;
         fc_ff <= fc_in;
         lc_ff <= lc_in;
      end
   end

   // Field checks, first failing rule wins.
   always_comb begin
      leap_f = leap_of(fy_ff, fp_ff, fc_ff);
      leap_l = leap_of(ly_ff, lp_ff, lc_ff);
      missing = (fy_ff == '0) || (fm_ff == '0) || (fd_ff == '0) ||
                (ly_ff == '0) || (lm_ff == '0) || (ld_ff == '0) ||
                (int'(fy_ff) > dcds_pkg::MAX_YEAR) || (int'(ly_ff) > dcds_pkg::MAX_YEAR);
      month_bad_f = fm_ff > dcds_pkg::MONTH_DEC;
      month_bad_l = lm_ff > dcds_pkg::MONTH_DEC;
      day_bad_f   = fd_ff > dcds_pkg::month_days(fm_ff, leap_f);
      day_bad_l   = ld_ff > dcds_pkg::month_days(lm_ff, leap_l);
      bad_date    = dcds_pkg::BAD_FIRST;
      if (missing) begin
         status = dcds_pkg::ST_MISSING;
      end else if (month_bad_f) begin
         status = dcds_pkg::ST_BAD_MONTH;
      end else if (day_bad_f) begin
         status = dcds_pkg::ST_BAD_DAY;
      end else if (month_bad_l) begin
         status   = dcds_pkg::ST_BAD_MONTH;
         bad_date = dcds_pkg::BAD_LAST;
      end else if (day_bad_l) begin
         status   = dcds_pkg::ST_BAD_DAY;
         bad_date = dcds_pkg::BAD_LAST;
      end else if (fy_ff > ly_ff) begin
         status = dcds_pkg::ST_YEAR_ORDER;
      end else if ((fy_ff == ly_ff) && (fm_ff > lm_ff)) begin
         status = dcds_pkg::ST_MONTH_ORDER;
      end else if ((fy_ff == ly_ff) && (fm_ff == lm_ff) && (fd_ff > ld_ff)) begin
         status = dcds_pkg::ST_DAY_ORDER;
      end else begin
         status = dcds_pkg::ST_OK;
      end
   end

   // Classified transaction into the queue.
   always_comb begin
      push                     = f1_valid_ff;
      push_job.status          = status;
      push_job.bad_date        = bad_date;
      push_job.first.prev_year = fp_ff;
      push_job.first.cent      = fc_ff;
      push_job.first.month     = fm_ff;
      push_job.first.day       = fd_ff;
      push_job.first.leap      = leap_f;
      push_job.last.prev_year  = lp_ff;
      push_job.last.cent       = lc_ff;
      push_job.last.month      = lm_ff;
      push_job.last.day        = ld_ff;
      push_job.last.leap       = leap_l;
   end

endmodule

// File: rtl/dcds_queue.sv
// ----------------------------------------------------------------------------
// Date check and day span: transaction queue
// A short first-in first-out queue of classified transactions between the
// front end and the back end.
// ----------------------------------------------------------------------------
module dcds_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  dcds_pkg::job_type          push_job,
   input  logic                       pop,
   output dcds_pkg::job_type          head,
   output dcds_pkg::queue_state_type  q_state
);

   dcds_pkg::job_type                 slot_ff [dcds_pkg::QDEPTH];
   logic [dcds_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [dcds_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [dcds_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_pop;

   // Pointer and occupancy update.
   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = push ? wr_ptr_ff + dcds_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + dcds_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + dcds_pkg::QCNT_W'(push) - dcds_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_comb begin
      head          = slot_ff[rd_ptr_ff];
      q_state.valid = count_ff != '0;
      q_state.count = count_ff;
   end

endmodule

// File: rtl/dcds_back.sv
// ----------------------------------------------------------------------------
// Date check and day span: back end
// Takes the oldest queued transaction, forms both day numbers, then their
// inclusive difference, and presents the response for one cycle.
// ----------------------------------------------------------------------------
module dcds_back (
   input  logic                             clock,
   input  logic                             reset,
   input  dcds_pkg::queue_state_type        q_state,
   input  dcds_pkg::job_type                head,
   output logic                             pop,
   output logic                             rsp_valid,
   output logic [dcds_pkg::TOTAL_W-1:0]     rsp_day_total,
   output logic [dcds_pkg::STATUS_W-1:0]    rsp_status,
   output logic                             rsp_bad_date
);

   logic                              b1_valid_ff, b1_valid_in;
   dcds_pkg::status_type              b1_status_ff;
   logic                              b1_bad_ff;
   logic [dcds_pkg::DAYNUM_W-1:0]     b1_first_ff, b1_first_in, b1_last_ff, b1_last_in;

   logic                              out_valid_ff, out_valid_in;
   logic [dcds_pkg::TOTAL_W-1:0]      out_total_ff, out_total_in;
   dcds_pkg::status_type              out_status_ff;
   logic                              out_bad_ff;
   logic [dcds_pkg::DAYNUM_W-1:0]     span;

   // The back end never stalls, so it drains one transaction per cycle.
   always_comb begin
      pop         = q_state.valid;
      b1_valid_in = q_state.valid;
      b1_first_in = dcds_pkg::day_number(head.first);
      b1_last_in  = dcds_pkg::day_number(head.last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_state.valid) begin
         b1_status_ff <= head.status;
         b1_bad_ff    <= head.bad_date;
         b1_first_ff  <= b1_first_in;
         b1_last_ff   <= b1_last_in;
      end
   end

   // Inclusive span, saturated to the output width; zero for any rejection.
   always_comb begin
      out_valid_in = b1_valid_ff;
      span         = b1_last_ff - b1_first_ff + dcds_pkg::DAYNUM_W'(1);
      if (b1_status_ff != dcds_pkg::ST_OK) begin
         out_total_in = '0;
      end else if (span > dcds_pkg::DAYNUM_W'(dcds_pkg::TOTAL_MAX)) begin
         out_total_in = dcds_pkg::TOTAL_MAX;
      end else begin
         out_total_in = span[dcds_pkg::TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (b1_valid_ff) begin
         out_total_ff  <= out_total_in;
         out_status_ff <= b1_status_ff;
         out_bad_ff    <= b1_bad_ff;
      end
   end

   always_comb begin
      rsp_valid     = out_valid_ff;
      rsp_day_total = out_total_ff;
      rsp_status    = out_status_ff;
      rsp_bad_date  = out_bad_ff;
   end

endmodule

// File: rtl/date_check_and_day_span_unit.sv
// ----------------------------------------------------------------------------
// Date check and day span unit
// Checks a start and an end Gregorian date and returns the inclusive number
// of days between them, or a status code naming the rejected field.
// ----------------------------------------------------------------------------
//   Channel   Ports                           Handshake
//   request   req_first_*, req_last_*         start high, busy low at the edge
//   response  rsp_day_total, rsp_status,      rsp_valid high for one cycle
//             rsp_bad_date
//
// One transaction can be accepted every cycle while busy is low. Each response
// passes the divide stage, check and queue, day numbers and difference
// registers in turn, and responses leave in request order.
// Reset is synchronous and active high; busy stays high while reset is high.
// The response side cannot stall, so the queue drains one transaction per
// cycle and busy rises only if the queue and the divide stage together
// could overfill it.
// ----------------------------------------------------------------------------
module date_check_and_day_span_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [dcds_pkg::YEAR_W-1:0]      req_first_year,
   input  logic [dcds_pkg::MONTH_W-1:0]     req_first_month,
   input  logic [dcds_pkg::DAY_W-1:0]       req_first_day,
   input  logic [dcds_pkg::YEAR_W-1:0]      req_last_year,
   input  logic [dcds_pkg::MONTH_W-1:0]     req_last_month,
   input  logic [dcds_pkg::DAY_W-1:0]       req_last_day,
   output logic                             rsp_valid,
   output logic [dcds_pkg::TOTAL_W-1:0]     rsp_day_total,
   output logic [dcds_pkg::STATUS_W-1:0]    rsp_status,
   output logic                             rsp_bad_date
);

   logic                       push;
   logic                       pop;
   dcds_pkg::job_type          push_job;
   dcds_pkg::job_type          head;
   dcds_pkg::queue_state_type  q_state;

   // Front end: accept and classify.
   dcds_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_first_year  (req_first_year),
      .req_first_month (req_first_month),
      .req_first_day   (req_first_day),
      .req_last_year   (req_last_year),
      .req_last_month  (req_last_month),
      .req_last_day    (req_last_day),
      .q_state         (q_state),
      .push            (push),
      .push_job        (push_job)
   );

   // Queue between the two halves.
   dcds_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .q_state  (q_state)
   );

   // Back end: day numbers and response.
   dcds_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_state       (q_state),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_day_total (rsp_day_total),
      .rsp_status    (rsp_status),
      .rsp_bad_date  (rsp_bad_date)
   );

endmodule

// File: rtl/dcds_checker.sv
// ----------------------------------------------------------------------------
// Date check and day span: port checker
// Watches the top-level ports for response timing and field consistency.
// ----------------------------------------------------------------------------
module dcds_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [dcds_pkg::TOTAL_W-1:0]     rsp_day_total,
   input logic [dcds_pkg::STATUS_W-1:0]    rsp_status,
   input logic                             rsp_bad_date
);

   // Every accepted transaction is answered by a response.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("accepted transaction produced no response");

   // No response appears without a matching accepted transaction.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("response without a matching transaction");

   // A rejected transaction carries a zero day count.
   a_zero_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != dcds_pkg::ST_OK)) |-> (rsp_day_total == '0))
      else $error("rejected transaction with nonzero day count");

   // The bad-date flag is only set for a bad month or bad day.
   a_bad_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_date) |->
         ((rsp_status == dcds_pkg::ST_BAD_MONTH) || (rsp_status == dcds_pkg::ST_BAD_DAY)))
      else $error("bad-date flag set with another status");

   // Nothing is presented in the cycle after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response right after reset");

endmodule

bind date_check_and_day_span_unit dcds_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_day_total (rsp_day_total),
   .rsp_status    (rsp_status),
   .rsp_bad_date  (rsp_bad_date)
);

// File: test/tb_date_check_and_day_span_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the date check and day span unit
// Sends start/end date pairs through the command interface and checks each
// response against its table row's result or a behavioral calendar model kept
// in the bench. A short table of directed pairs comes first, then randomized
// pairs, mostly well-formed, with a share of corrupted, missing and noise fields.
// ----------------------------------------------------------------------------
module tb_date_check_and_day_span_unit;

   localparam int RANDOM_ITEMS = 650;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 12;
   localparam int NUM_ROWS     = 25;

   // Expected content of one response transaction.
   typedef struct packed {
      logic [dcds_pkg::TOTAL_W-1:0] total;
      dcds_pkg::status_type         status;
      logic                         bad;
   } span_result_type;

   // One directed stimulus row; known rows carry their response inline.
   typedef struct packed {
      logic [dcds_pkg::YEAR_W-1:0]  fy;
      logic [dcds_pkg::MONTH_W-1:0] fm;
      logic [dcds_pkg::DAY_W-1:0]   fd;
      logic [dcds_pkg::YEAR_W-1:0]  ly;
      logic [dcds_pkg::MONTH_W-1:0] lm;
      logic [dcds_pkg::DAY_W-1:0]   ld;
      logic                         known;
      span_result_type              result;
   } date_row_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [dcds_pkg::YEAR_W-1:0]   req_first_year;
   logic [dcds_pkg::MONTH_W-1:0]  req_first_month;
   logic [dcds_pkg::DAY_W-1:0]    req_first_day;
   logic [dcds_pkg::YEAR_W-1:0]   req_last_year;
   logic [dcds_pkg::MONTH_W-1:0]  req_last_month;
   logic [dcds_pkg::DAY_W-1:0]    req_last_day;
   logic                          rsp_valid;
   logic [dcds_pkg::TOTAL_W-1:0]  rsp_day_total;
   logic [dcds_pkg::STATUS_W-1:0] rsp_status;
   logic                          rsp_bad_date;

   // Typed response for the transaction being offered, if it has one.
   logic                row_known;
   span_result_type     row_result;

   span_result_type     pending_spans[$];
   int                  error_count  = 0;
   int                  ok_count     = 0;
   int                  reject_count = 0;
   int                  idle_cycles  = 0;
   int                  burst_left   = 0;

   date_row_type directed_rows [NUM_ROWS] = '{
      // Extremes of the calendar range.
      '{1,     1,  1,  1,     1,  1,  1, '{1,       dcds_pkg::ST_OK, dcds_pkg::BAD_FIRST}},
      '{1,     1,  1,  9999,  12, 31, 1, '{3652059, dcds_pkg::ST_OK, dcds_pkg::BAD_FIRST}},
      '{9999,  12, 31, 9999,  12, 31, 1, '{1,       dcds_pkg::ST_OK, dcds_pkg::BAD_FIRST}},
      // Each field missing in turn.
      '{0,     5,  5,  2000,  5,  5,  1, '{0, dcds_pkg::ST_MISSING, dcds_pkg::BAD_FIRST}},
      '{2000,  0,  5,  2000,  5,  5,  1, '{0, dcds_pkg::ST_MISSING, dcds_pkg::BAD_FIRST}},
      '{2000,  5,  0,  2000,  5,  5,  1, '{0, dcds_pkg::ST_MISSING, dcds_pkg::BAD_FIRST}},
      '{2000,  5,  5,  0,     5,  5,  1, '{0, dcds_pkg::ST_MISSING, dcds_pkg::BAD_FIRST}},
      '{2000,  5,  5,  2000,  0,  5,  1, '{0, dcds_pkg::ST_MISSING, dcds_pkg::BAD_FIRST}},
      '{2000,  5,  5,  2000,  5,  0,  1, '{0, dcds_pkg::ST_MISSING, dcds_pkg::BAD_FIRST}},
      // Years beyond the supported range count as missing.
      '{10000, 1,  1,  10000, 1,  1,  1, '{0, dcds_pkg::ST_MISSING, dcds_pkg::BAD_FIRST}},
      '{1,     1,  1,  16383, 1,  1,  1, '{0, dcds_pkg::ST_MISSING, dcds_pkg::BAD_FIRST}},
      // Month codes 13 to 15 on either side.
      '{2000,  13, 1,  2000,  1,  1,  1, '{0, dcds_pkg::ST_BAD_MONTH, dcds_pkg::BAD_FIRST}},
      '{2000,  1,  1,  2000,  15, 1,  1, '{0, dcds_pkg::ST_BAD_MONTH, dcds_pkg::BAD_LAST}},
      // Days past the end of the month, including the century leap rule.
      '{2000,  4,  31, 2000,  5,  1,  1, '{0, dcds_pkg::ST_BAD_DAY, dcds_pkg::BAD_FIRST}},
      '{1800,  1,  1,  1900,  2,  29, 1, '{0, dcds_pkg::ST_BAD_DAY, dcds_pkg::BAD_LAST}},
      '{2100,  2,  29, 2200,  1,  1,  1, '{0, dcds_pkg::ST_BAD_DAY, dcds_pkg::BAD_FIRST}},
      '{2000,  2,  29, 2000,  2,  29, 1, '{1, dcds_pkg::ST_OK,      dcds_pkg::BAD_FIRST}},
      '{2024,  2,  29, 2024,  3,  1,  1, '{2, dcds_pkg::ST_OK,      dcds_pkg::BAD_FIRST}},
      // Start after end, by year, by month and by day.
      '{2001,  1,  1,  2000,  12, 31, 1, '{0, dcds_pkg::ST_YEAR_ORDER, dcds_pkg::BAD_FIRST}},
      '{2000,  5,  1,  2000,  4,  30, 1, '{0, dcds_pkg::ST_MONTH_ORDER, dcds_pkg::BAD_FIRST}},
      '{2000,  5,  10, 2000,  5,  9,  1, '{0, dcds_pkg::ST_DAY_ORDER, dcds_pkg::BAD_FIRST}},
      // The start date is judged before the end date.
      '{2000,  14, 1,  2001,  2,  31, 1, '{0, dcds_pkg::ST_BAD_MONTH, dcds_pkg::BAD_FIRST}},
      '{1999,  12, 31, 2000,  1,  1,  1, '{2, dcds_pkg::ST_OK,        dcds_pkg::BAD_FIRST}},
      // A long span left to the model, then every field at its largest code.
      '{1582,  10, 15, 2024,  6,  30, 0, '{0, dcds_pkg::ST_OK,      dcds_pkg::BAD_FIRST}},
      '{16383, 15, 31, 16383, 15, 31, 1, '{0, dcds_pkg::ST_MISSING, dcds_pkg::BAD_FIRST}}
   };

   date_check_and_day_span_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_first_year  (req_first_year),
      .req_first_month (req_first_month),
      .req_first_day   (req_first_day),
      .req_last_year   (req_last_year),
      .req_last_month  (req_last_month),
      .req_last_day    (req_last_day),
      .rsp_valid       (rsp_valid),
      .rsp_day_total   (rsp_day_total),
      .rsp_status      (rsp_status),
      .rsp_bad_date    (rsp_bad_date)
   );

   // Free-running clock with a period of two time units.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Gregorian leap rule.
   function automatic bit leap_year(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // Length of a month; zero for codes that name no month.
   function automatic int unsigned month_length(input int unsigned m, input bit leap);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   // Ordinal of a valid date, counting 1 January of year 1 as day 1.
   function automatic int unsigned ordinal_day(input int unsigned y, input int unsigned m,
                                               input int unsigned d);
      int unsigned n;
      n = 365 * (y - 1) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
      for (int k = 1; k < m; k++)
         n += month_length(k, leap_year(y));
      return n + d;
   endfunction

   // Fault found in one date, assuming month and day are nonzero.
   function automatic dcds_pkg::status_type date_fault(input int unsigned y,
                                                       input int unsigned m,
                                                       input int unsigned d);
      if (m > 12)
         return dcds_pkg::ST_BAD_MONTH;
      if (d > month_length(m, leap_year(y)))
         return dcds_pkg::ST_BAD_DAY;
      return dcds_pkg::ST_OK;
   endfunction

   // Response the unit should give for one date pair.
   function automatic span_result_type predict_span(
      input logic [dcds_pkg::YEAR_W-1:0] fy, input logic [dcds_pkg::MONTH_W-1:0] fm,
      input logic [dcds_pkg::DAY_W-1:0] fd, input logic [dcds_pkg::YEAR_W-1:0] ly,
      input logic [dcds_pkg::MONTH_W-1:0] lm, input logic [dcds_pkg::DAY_W-1:0] ld);
      span_result_type      r;
      dcds_pkg::status_type first_fault;
      dcds_pkg::status_type last_fault;
      int unsigned          span;
      r.total     = '0;
      r.status    = dcds_pkg::ST_OK;
      r.bad       = dcds_pkg::BAD_FIRST;
      first_fault = date_fault(fy, fm, fd);
      last_fault  = date_fault(ly, lm, ld);
      if (fy == 0 || fm == 0 || fd == 0 || ly == 0 || lm == 0 || ld == 0 ||
          fy > dcds_pkg::MAX_YEAR || ly > dcds_pkg::MAX_YEAR) begin
         r.status = dcds_pkg::ST_MISSING;
      end else if (first_fault != dcds_pkg::ST_OK) begin
         r.status = first_fault;
      end else if (last_fault != dcds_pkg::ST_OK) begin
         r.status = last_fault;
         r.bad    = dcds_pkg::BAD_LAST;
      end else if (fy > ly) begin
         r.status = dcds_pkg::ST_YEAR_ORDER;
      end else if (fy == ly && fm > lm) begin
         r.status = dcds_pkg::ST_MONTH_ORDER;
      end else if (fy == ly && fm == lm && fd > ld) begin
         r.status = dcds_pkg::ST_DAY_ORDER;
      end else begin
         span    = ordinal_day(ly, lm, ld) - ordinal_day(fy, fm, fd) + 1;
         r.total = (span > dcds_pkg::TOTAL_MAX) ? dcds_pkg::TOTAL_MAX
                                                : dcds_pkg::TOTAL_W'(span);
      end
      return r;
   endfunction

   // Idle gap before the next transaction: mostly none, a few long ones,
   // and now and then a stretch with no gaps at all.
   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         burst_left = $urandom_range(20, 50);
         return 0;
      end
      if (r < 60)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // A random valid date, with the ends of the year range favored a little.
   task automatic random_date(output logic [dcds_pkg::YEAR_W-1:0] y,
                              output logic [dcds_pkg::MONTH_W-1:0] m,
                              output logic [dcds_pkg::DAY_W-1:0] d);
      case ($urandom_range(0, 15))
         0:       y = dcds_pkg::YEAR_W'(1);
         1:       y = dcds_pkg::YEAR_W'(dcds_pkg::MAX_YEAR);
         default: y = dcds_pkg::YEAR_W'($urandom_range(1, dcds_pkg::MAX_YEAR));
      endcase
      m = dcds_pkg::MONTH_W'($urandom_range(1, 12));
      d = dcds_pkg::DAY_W'($urandom_range(1, month_length(m, leap_year(y))));
   endtask

   // Offer one transaction after an idle gap and hold it until accepted.
   task automatic send_dates(
      input logic [dcds_pkg::YEAR_W-1:0] fy, input logic [dcds_pkg::MONTH_W-1:0] fm,
      input logic [dcds_pkg::DAY_W-1:0] fd, input logic [dcds_pkg::YEAR_W-1:0] ly,
      input logic [dcds_pkg::MONTH_W-1:0] lm, input logic [dcds_pkg::DAY_W-1:0] ld,
      input logic known, input span_result_type result);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start           <= 1'b1;
      req_first_year  <= fy;
      req_first_month <= fm;
      req_first_day   <= fd;
      req_last_year   <= ly;
      req_last_month  <= lm;
      req_last_day    <= ld;
      row_known       <= known;
      row_result      <= result;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
   endtask

   // Record accepted transactions, check responses, and watch for a hang.
   always @(posedge clock) begin : response_check
      span_result_type want;
      span_result_type queued;
      logic            active;
      active = 1'b0;
      if (start === 1'b1 && busy === 1'b0) begin
         active = 1'b1;
         if (row_known)
            queued = row_result;
         else
            queued = predict_span(req_first_year, req_first_month, req_first_day,
                                  req_last_year, req_last_month, req_last_day);
         pending_spans.insert(pending_spans.size(), queued);
      end
      if (rsp_valid === 1'b1) begin
         active = 1'b1;
         if (pending_spans.size() == 0) begin
            $display("%0t: response with nothing outstanding: total %0d status %0d bad %0b",
                     $time, rsp_day_total, rsp_status, rsp_bad_date);
            error_count++;
         end else begin
            want = pending_spans.pop_front();
            if (want.status == dcds_pkg::ST_OK)
               ok_count++;
            else
               reject_count++;
            if (rsp_day_total !== want.total) begin
               $display("%0t: day_total expected %0d, got %0d", $time, want.total,
                        rsp_day_total);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_bad_date !== want.bad) begin
               $display("%0t: bad_date expected %0b, got %0b", $time, want.bad,
                        rsp_bad_date);
               error_count++;
            end
         end
      end
      idle_cycles = active ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d responses outstanding",
                  $time, IDLE_LIMIT, pending_spans.size());
         $display("date_check_and_day_span_unit test failed");
         $finish;
      end
   end

   // Reset, directed table, randomized pairs, then drain.
   initial begin : stimulus
      logic [dcds_pkg::YEAR_W-1:0]  fy, ly;
      logic [dcds_pkg::MONTH_W-1:0] fm, lm;
      logic [dcds_pkg::DAY_W-1:0]   fd, ld;
      logic [dcds_pkg::DAY_W-1:0]   len;
      span_result_type              none;
      int                           pick;
      none            = '{0, dcds_pkg::ST_OK, dcds_pkg::BAD_FIRST};
      reset           = 1'b1;
      start           = 1'b0;
      req_first_year  = '0;
      req_first_month = '0;
      req_first_day   = '0;
      req_last_year   = '0;
      req_last_month  = '0;
      req_last_day    = '0;
      row_known       = 1'b0;
      row_result      = none;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (directed_rows[i])
         send_dates(directed_rows[i].fy, directed_rows[i].fm, directed_rows[i].fd,
                    directed_rows[i].ly, directed_rows[i].lm, directed_rows[i].ld,
                    directed_rows[i].known, directed_rows[i].result);

      // Randomized pairs: mostly valid spans, the rest broken on purpose.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         random_date(fy, fm, fd);
         random_date(ly, lm, ld);
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // Valid pair; often in the same year or month to reach the order checks.
            if ($urandom_range(0, 3) == 0) begin
               ly = fy;
               if ($urandom_range(0, 1) == 1)
                  lm = fm;
               ld = dcds_pkg::DAY_W'($urandom_range(1, month_length(lm, leap_year(ly))));
            end
            if ($urandom_range(0, 4) != 0 && {fy, fm, fd} > {ly, lm, ld}) begin
               {fy, fm, fd, ly, lm, ld} = {ly, lm, ld, fy, fm, fd};
            end
         end else if (pick < 85) begin
            // One date gets a bad month or a day past the month's end.
            if ($urandom_range(0, 1) == 0) begin
               len = dcds_pkg::DAY_W'(month_length(fm, leap_year(fy)));
               if (len == 31 || $urandom_range(0, 2) == 0)
                  fm = dcds_pkg::MONTH_W'($urandom_range(13, 15));
               else
                  fd = dcds_pkg::DAY_W'($urandom_range(len + 1, 31));
            end else begin
               len = dcds_pkg::DAY_W'(month_length(lm, leap_year(ly)));
               if (len == 31 || $urandom_range(0, 2) == 0)
                  lm = dcds_pkg::MONTH_W'($urandom_range(13, 15));
               else
                  ld = dcds_pkg::DAY_W'($urandom_range(len + 1, 31));
            end
         end else if (pick < 93) begin
            // A missing field or a year past the top of the range.
            case ($urandom_range(0, 7))
               0: fy = '0;
               1: fm = '0;
               2: fd = '0;
               3: ly = '0;
               4: lm = '0;
               5: ld = '0;
               6: fy = dcds_pkg::YEAR_W'($urandom_range(dcds_pkg::MAX_YEAR + 1,
                                                         2 ** dcds_pkg::YEAR_W - 1));
               default: ly = dcds_pkg::YEAR_W'($urandom_range(dcds_pkg::MAX_YEAR + 1,
                                                              2 ** dcds_pkg::YEAR_W - 1));
            endcase
         end else begin
            // Raw noise over every field.
            fy = dcds_pkg::YEAR_W'($urandom);
            fm = dcds_pkg::MONTH_W'($urandom);
            fd = dcds_pkg::DAY_W'($urandom);
            ly = dcds_pkg::YEAR_W'($urandom);
            lm = dcds_pkg::MONTH_W'($urandom);
            ld = dcds_pkg::DAY_W'($urandom);
         end
         send_dates(fy, fm, fd, ly, lm, ld, 1'b0, none);
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending_spans.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d directed and %0d random date pairs.", NUM_ROWS, RANDOM_ITEMS);
      $display("Responses checked: %0d day spans, %0d rejections, %0d mismatches.",
               ok_count, reject_count, error_count);
      if (error_count == 0)
         $display("date_check_and_day_span_unit test passed");
      else
         $display("date_check_and_day_span_unit test failed");
      $finish;
   end

endmodule
